@@ hdl/sket_pkg.sv @@
package sket_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAP_W-1:0] GAP_RESET   = 16'd400;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd4;
  localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;
  localparam logic [CNT_W-1:0] CNT_INIT    = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP = 1'b0,
    CFG_LIMIT   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_NO_ENTRY = 3'd0,
    ACT_INSERTED = 3'd1,
    ACT_CLEARED  = 3'd2,
    ACT_ALERTED  = 3'd3,
    ACT_COUNTED  = 3'd4,
    ACT_ALERT    = 3'd5
  } action_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  count;
  } meta_t;

endpackage

@@ hdl/suspicious_key_event_tracker.sv @@
// Tracks keys reported missing across events and raises a one-time alert per
// key. Each beat accepted on start (while busy is low) scans the key table
// one slot per clock through the key memory's single read port, up to the
// first match or the last filled slot, then updates in ST_HIT or ST_MISS
// before busy falls; an empty table goes straight to ST_MISS. The result
// appears on the out_ ports for exactly one cycle with out_valid high, in
// the first cycle that busy is low; the receiver cannot stall it, and a new
// event may be started in that same cycle. Configuration must be written
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
module suspicious_key_event_tracker #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sket_pkg::KEY_W-1:0]          in_process_key,
  input  logic                                in_found,
  input  logic [sket_pkg::TIME_W-1:0]         in_now_ms,
  input  logic                                cfg_we,
  input  logic [sket_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sket_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic [2:0]                          out_action,
  output logic                                out_alert,
  output logic                                out_hit,
  output logic [sket_pkg::SLOT_W-1:0]         out_slot,
  output logic                                out_visible_after_alert
);
  import sket_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS
  } state_t;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  meta_t            meta_mem [TABLE_ENTRIES];

  state_t            state_r;
  logic [GAP_W-1:0]  min_gap_r;
  logic [CNT_W-1:0]  limit_r;
  logic [FILL_W-1:0] fill_r;
  logic [IDX_W-1:0]  wptr_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [KEY_W-1:0]  key_r;
  logic              found_r;
  logic [TIME_W-1:0] now_r;
  logic [KEY_W-1:0]  key_q;
  meta_t             meta_q;

  logic              out_valid_r;
  action_t           out_action_r;
  logic              out_alert_r;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_vis_r;

  logic [IDX_W-1:0]  key_raddr;
  logic              key_we;
  logic [IDX_W-1:0]  key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  meta_t             meta_wdata;

  logic              match;
  logic              scan_last;
  logic [TIME_W-1:0] gap;
  logic              gap_ok;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [31:0]       cmp_slot_ext;
  logic [31:0]       wptr_slot_ext;

  assign match        = (key_q == key_r);
  assign scan_last    = ((FILL_W'(cmp_idx_r) + 1'b1) == fill_r);
  assign gap          = now_r - meta_q.stamp;
  assign gap_ok       = (gap > TIME_W'(min_gap_r));
  assign cmp_slot_ext = 32'(cmp_idx_r);
  assign wptr_slot_ext = 32'(wptr_r);

  always_comb begin
    cnt_nxt = meta_q.count;
    if (gap_ok && (meta_q.count != CNT_MAX)) begin
      cnt_nxt = meta_q.count + 1'b1;
    end
  end

  assign key_raddr = (state_r == ST_IDLE) ? '0 : IDX_W'(cmp_idx_r + 1'b1);

  always_comb begin
    key_we     = 1'b0;
    key_waddr  = wptr_r;
    key_wdata  = key_r;
    meta_we    = 1'b0;
    meta_waddr = wptr_r;
    meta_wdata = '{stamp: now_r, count: CNT_INIT};
    case (state_r)
      ST_HIT: begin
        key_waddr  = cmp_idx_r;
        key_wdata  = '0;
        meta_waddr = cmp_idx_r;
        meta_wdata = '{stamp: now_r, count: cnt_nxt};
        if (found_r) begin
          key_we = 1'b1;
        end else if ((meta_q.count <= limit_r) && gap_ok) begin
          meta_we = 1'b1;
        end
      end
      ST_MISS: begin
        key_we  = !found_r;
        meta_we = !found_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[cmp_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= GAP_RESET;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_GAP: min_gap_r <= cfg_data;
        CFG_LIMIT:   limit_r   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wptr_r      <= '0;
      cmp_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            key_r     <= in_process_key;
            found_r   <= in_found;
            now_r     <= in_now_ms;
            cmp_idx_r <= '0;
            state_r   <= (fill_r == '0) ? ST_MISS : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // advance one slot a cycle until a match or the last filled slot
          if (match) begin
            state_r <= ST_HIT;
          end else if (scan_last) begin
            state_r <= ST_MISS;
          end else begin
            cmp_idx_r <= cmp_idx_r + 1'b1;
          end
        end
        ST_HIT: begin
          out_valid_r  <= 1'b1;
          out_hit_r    <= 1'b1;
          out_slot_r   <= cmp_slot_ext[SLOT_W-1:0];
          out_alert_r  <= 1'b0;
          out_vis_r    <= 1'b0;
          if (found_r) begin
            out_action_r <= ACT_CLEARED;
            out_vis_r    <= (meta_q.count > limit_r);
          end else if (meta_q.count > limit_r) begin
            out_action_r <= ACT_ALERTED;
          end else if (cnt_nxt > limit_r) begin
            out_action_r <= ACT_ALERT;
            out_alert_r  <= 1'b1;
          end else begin
            out_action_r <= ACT_COUNTED;
          end
          state_r <= ST_IDLE;
        end
        ST_MISS: begin
          out_valid_r <= 1'b1;
          out_hit_r   <= 1'b0;
          out_alert_r <= 1'b0;
          out_vis_r   <= 1'b0;
          if (found_r) begin
            out_action_r <= ACT_NO_ENTRY;
            out_slot_r   <= '0;
          end else begin
            out_action_r <= ACT_INSERTED;
            out_slot_r   <= wptr_slot_ext[SLOT_W-1:0];
            if (fill_r != FILL_MAX) begin
              fill_r <= fill_r + 1'b1;
            end
            wptr_r <= (wptr_r == IDX_LAST) ? '0 : IDX_W'(wptr_r + 1'b1);
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy                    = (state_r != ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_action              = out_action_r;
  assign out_alert               = out_alert_r;
  assign out_hit                 = out_hit_r;
  assign out_slot                = out_slot_r;
  assign out_visible_after_alert = out_vis_r;

endmodule
